// File: sv/core_pkg.sv
package core_pkg;

  // Fixed point and framing
  localparam int RATE_FRAC_BITS = 32;
  localparam int STAMP_BYTES    = 8;

  // Field widths
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int STAMP_W = 64;
  localparam int RATE_W  = 34;
  localparam int PROD_W  = RATE_W + STAMP_W;

  // Byte store and counters
  localparam int STORE_DEPTH = 2 * STAMP_BYTES;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int DIV_STEPS   = STAMP_W + RATE_FRAC_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // Event codes
  localparam logic [OP_W-1:0] OP_SYNC_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE_ONE = 2'd1;
  localparam logic [OP_W-1:0] OP_PROBE_TWO = 2'd2;

endpackage

// File: sv/core_evt_if.sv
interface core_evt_if;
  logic                        valid;
  logic                        ready;
  logic [core_pkg::OP_W-1:0]    op;
  logic [core_pkg::BYTE_W-1:0]  rx_byte;
  logic [core_pkg::STAMP_W-1:0] now_us;

  modport source (output valid, op, rx_byte, now_us, input ready);
  modport sink   (input valid, op, rx_byte, now_us, output ready);
endinterface

// File: sv/core_est_if.sv
interface core_est_if;
  logic                               valid;
  logic                               ready;
  logic        [core_pkg::RATE_W-1:0]  rate_q32;
  logic signed [core_pkg::STAMP_W-1:0] offset_us;
  logic                               first_sync;
  logic                               rate_invalid;

  modport source (output valid, rate_q32, offset_us, first_sync, rate_invalid, input ready);
  modport sink   (input valid, rate_q32, offset_us, first_sync, rate_invalid, output ready);
endinterface

// File: sv/clock_offset_rate_estimator_unit.sv
// Channel  Dir  Beat contents
// evt      in   op, rx_byte, now_us (probe stamps and sync bytes)
// est      out  rate_q32, offset_us, first_sync, rate_invalid
//
// Probe events and non-final bytes are taken in the idle state and leave it idle.
// A timestamp's final byte starts a bit-serial run: a first sync runs a restoring
// divide (one quotient bit a cycle over 64+RATE_FRAC_BITS steps, skipped when the
// master interval is zero), then a 34-step shift-add multiply; later syncs run only the multiply.
// rst is synchronous and clears counters, probe stamps and the stored rate.
// A result waits in the output register; events are taken meanwhile, and a
// further result holds the core until that register is free.
module clock_offset_rate_estimator_unit (
  input  logic       clk,
  input  logic       rst,
  core_evt_if.sink   evt,
  core_est_if.source est
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MID0   = 4'd1;
  localparam logic [3:0] S_MID1   = 4'd2;
  localparam logic [3:0] S_DSUB   = 4'd3;
  localparam logic [3:0] S_NSUB   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_MSTART = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_OFFS   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam int SW = core_pkg::STAMP_W;
  localparam int RW = core_pkg::RATE_W;

  logic [3:0] state;

  // Control and sync state
  logic [core_pkg::CNT_W-1:0]  byte_count;
  logic                        synced;
  logic [SW-1:0]               probe_one;
  logic [SW-1:0]               probe_two;
  logic [SW-1:0]               first_reply;
  logic [RW-1:0]               rate_store;
  logic                        first_r;
  logic                        bad_r;
  logic [core_pkg::STEP_W-1:0] step;

  // Byte store, written at the count, read at fixed lanes
  logic [core_pkg::BYTE_W-1:0] byte_store [core_pkg::STORE_DEPTH];

  // Datapath registers
  logic [SW-1:0] work;       // now, then second midpoint, then dividend shifter
  logic [SW-1:0] den;
  logic [SW-1:0] rem;
  logic [RW-1:0] quo;
  logic          quo_ovf;
  logic [RW-1:0] mrate;
  logic [SW-1:0] acc_hi;
  logic [RW-1:0] acc_lo;
  logic [SW-1:0] offset_r;

  // Output register
  logic                 out_valid;
  logic [RW-1:0]        out_rate;
  logic signed [SW-1:0] out_offset;
  logic                 out_first;
  logic                 out_bad;

  logic [core_pkg::CNT_W-1:0] count_inc;
  logic                       accept;
  logic                       out_load;

  logic [SW-1:0] m0;
  logic [SW-1:0] m1;

  logic [SW-1:0] mid_a;
  logic [SW-1:0] mid_b;
  logic [SW:0]   mid_sum;
  logic [SW-1:0] sub_a;
  logic [SW-1:0] sub_b;
  logic [SW-1:0] sub_diff;

  logic [SW:0]   rem_sh;
  logic [SW:0]   rem_dif;
  logic          rem_ge;
  logic [SW-1:0] rem_next;
  logic [RW-1:0] quo_next;

  logic [SW:0]       madd;
  logic [core_pkg::PROD_W-1:0] product;
  logic [SW-1:0]     scaled;
  logic [SW:0]       odiff;

  assign accept    = evt.valid && evt.ready;
  assign evt.ready = (state == S_IDLE);
  assign count_inc = byte_count + 1'b1;
  assign out_load  = (state == S_DONE) && (!out_valid || est.ready);

  // Assemble the two little-endian master stamps
  always_comb begin
    m0 = '0;
    m1 = '0;
    for (int i = 0; i < core_pkg::STAMP_BYTES; i++) begin
      m0[8*i +: 8] = byte_store[i];
      m1[8*i +: 8] = byte_store[core_pkg::STAMP_BYTES + i];
    end
  end

  // Shared midpoint adder, 65-bit sum so it never wraps
  always_comb begin
    mid_a = probe_one;
    mid_b = first_r ? first_reply : work;
    if (state == S_MID1) begin
      mid_a = probe_two;
      mid_b = work;
    end
    mid_sum = {1'b0, mid_a} + {1'b0, mid_b};
  end

  // Shared interval subtractor, modulo 2^64
  always_comb begin
    sub_a = work;
    sub_b = probe_one;
    if (state == S_DSUB) begin
      sub_a = m1;
      sub_b = m0;
    end
    sub_diff = sub_a - sub_b;
  end

  // One restoring divide step
  always_comb begin
    rem_sh   = {rem, work[SW-1]};
    rem_ge   = (rem_sh >= {1'b0, den});
    rem_dif  = rem_sh - {1'b0, den};
    rem_next = rem_ge ? rem_dif[SW-1:0] : rem_sh[SW-1:0];
    quo_next = {quo[RW-2:0], rem_ge};
  end

  // One shift-add multiply step, rate LSB first
  assign madd = {1'b0, acc_hi} + (mrate[0] ? {1'b0, m0} : {(SW+1){1'b0}});

  // Scale, saturate, and form the offset difference (clamped to the signed range in S_OFFS)
  always_comb begin
    product = {acc_hi, acc_lo};
    if ((product >> (core_pkg::RATE_FRAC_BITS + SW)) != 0) begin
      scaled = {SW{1'b1}};
    end else begin
      scaled = SW'(product >> core_pkg::RATE_FRAC_BITS);
    end
    odiff = {1'b0, probe_one} - {1'b0, scaled};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_count  <= '0;
      synced      <= 1'b0;
      probe_one   <= '0;
      probe_two   <= '0;
      first_reply <= '0;
      rate_store  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (evt.op)
              core_pkg::OP_PROBE_ONE: probe_one <= evt.now_us;
              core_pkg::OP_PROBE_TWO: probe_two <= evt.now_us;
              core_pkg::OP_SYNC_BYTE: begin
                if (byte_count < core_pkg::CNT_W'(core_pkg::STORE_DEPTH)) begin
                  byte_count <= count_inc;
                  if (!synced && count_inc == core_pkg::CNT_W'(core_pkg::STAMP_BYTES)) begin
                    first_reply <= evt.now_us;
                  end
                  if ((!synced && count_inc == core_pkg::CNT_W'(core_pkg::STORE_DEPTH)) ||
                      (synced && count_inc == core_pkg::CNT_W'(core_pkg::STAMP_BYTES))) begin
                    state <= S_MID0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_MID0: begin
          byte_count <= '0;
          probe_one  <= mid_sum[SW:1];
          state      <= first_r ? S_MID1 : S_MSTART;
        end
        S_MID1:   state <= S_DSUB;
        S_DSUB:   state <= S_NSUB;
        S_NSUB: begin
          synced <= 1'b1;
          if (den == '0) begin
            rate_store <= core_pkg::RATE_MAX;
            state      <= S_MSTART;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == core_pkg::STEP_W'(core_pkg::DIV_STEPS - 1)) begin
            rate_store <= (quo_ovf || quo[RW-1]) ? core_pkg::RATE_MAX : quo_next;
            state      <= S_MSTART;
          end
        end
        S_MSTART: state <= S_MUL;
        S_MUL: begin
          if (step == core_pkg::STEP_W'(RW - 1)) begin
            state <= S_OFFS;
          end
        end
        S_OFFS: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && evt.op == core_pkg::OP_SYNC_BYTE &&
            byte_count < core_pkg::CNT_W'(core_pkg::STORE_DEPTH)) begin
          byte_store[byte_count[core_pkg::IDX_W-1:0]] <= evt.rx_byte;
          work    <= evt.now_us;
          first_r <= !synced;
          bad_r   <= 1'b0;
        end
      end
      S_MID1: work <= mid_sum[SW:1];
      S_DSUB: den  <= sub_diff;
      S_NSUB: begin
        work    <= sub_diff;
        bad_r   <= (den == '0);
        rem     <= '0;
        quo     <= '0;
        quo_ovf <= 1'b0;
        step    <= '0;
      end
      S_DIV: begin
        work    <= {work[SW-2:0], 1'b0};
        rem     <= rem_next;
        quo     <= quo_next;
        quo_ovf <= quo_ovf | quo[RW-1];
        step    <= step + 1'b1;
      end
      S_MSTART: begin
        mrate  <= rate_store;
        acc_hi <= '0;
        acc_lo <= '0;
        step   <= '0;
      end
      S_MUL: begin
        acc_hi <= madd[SW:1];
        acc_lo <= {madd[0], acc_lo[RW-1:1]};
        mrate  <= {1'b0, mrate[RW-1:1]};
        step   <= step + 1'b1;
      end
      S_OFFS: begin
        if (odiff[SW] != odiff[SW-1]) begin
          offset_r <= odiff[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
          offset_r <= odiff[SW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (est.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate   <= rate_store;
      out_offset <= offset_r;
      out_first  <= first_r;
      out_bad    <= first_r && bad_r;
    end
  end

  assign est.valid        = out_valid;
  assign est.rate_q32     = out_rate;
  assign est.offset_us    = out_offset;
  assign est.first_sync   = out_first;
  assign est.rate_invalid = out_bad;

  // Checks
  a_invalid_rate: assert property (@(posedge clk) disable iff (rst)
    est.valid && est.rate_invalid |-> est.first_sync && est.rate_q32 == core_pkg::RATE_MAX)
    else $error("rate_invalid without saturated first-sync rate");

  a_synced_count: assert property (@(posedge clk) disable iff (rst)
    synced |-> byte_count <= core_pkg::CNT_W'(core_pkg::STAMP_BYTES))
    else $error("byte count past one stamp while synced");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != '0)
    else $error("divide running with zero master interval");

endmodule
